// File: rtl/rsb_pkg.sv
// Shared types and constants for the run-length sprite blitter.
// No dependencies; imported by the sequencer, the output stage, the top level and the testbench.
package rsb_pkg;

	// Fixed widths and table sizes of the pixel format.
	localparam int PIXEL_BITS      = 16;
	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = 8;
	localparam int SHADE_ENTRIES_DEFAULT = 65536;

	localparam logic [15:0] PITCH_RESET  = 16'd1280;
	localparam logic [7:0]  SHADOW_PIXEL = 8'd254;

	// Item operation codes.
	typedef enum logic [1:0] {
		OP_START      = 2'd0,
		OP_BYTE       = 2'd1,
		OP_LOAD_PAL   = 2'd2,
		OP_LOAD_SHADE = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_REJECT    = 2'd1,
		ST_IDLE_BYTE = 2'd2
	} status_t;

	// Result of one item before the color lookup is resolved.
	typedef struct packed {
		logic          we;
		logic          shadow;
		logic [31:0]   woff;
		logic [31:0]   next_off;
		logic          done;
		status_t       status;
	} res_t;

endpackage

// File: rtl/rsb_ifs.sv
// Valid/ready channel interfaces for sprite items and pixel results.
// Depends on nothing; used by the top level and its submodules.
interface rsb_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [7:0]         src_byte;
	logic signed [15:0] coord_x;
	logic signed [15:0] coord_y;
	logic signed [15:0] offset_x;
	logic signed [15:0] offset_y;
	logic [15:0]        height;
	logic [15:0]        ref_depth;
	logic [15:0]        dest_pixel;
	logic [15:0]        depth_at_cursor;
	logic [15:0]        table_index;
	logic [15:0]        table_value;

	modport source (output valid, operation, src_byte, coord_x, coord_y, offset_x, offset_y,
		height, ref_depth, dest_pixel, depth_at_cursor, table_index, table_value,
		input ready);
	modport sink (input valid, operation, src_byte, coord_x, coord_y, offset_x, offset_y,
		height, ref_depth, dest_pixel, depth_at_cursor, table_index, table_value,
		output ready);
endinterface

interface rsb_out_if;
	logic        valid;
	logic        ready;
	logic        write_enable;
	logic [31:0] write_offset;
	logic [15:0] write_value;
	logic [31:0] next_offset;
	logic        sprite_done;
	logic [1:0]  status;

	modport source (output valid, write_enable, write_offset, write_value, next_offset,
		sprite_done, status, input ready);
	modport sink (input valid, write_enable, write_offset, write_value, next_offset,
		sprite_done, status, output ready);
endinterface

// File: rtl/rsb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rsb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/rsb_seq.sv
// Stream sequencer: cursor, row and run state, item decode and the first stage.
// Depends on rsb_pkg and the input channel interface in rsb_ifs.sv.
module rsb_seq
	import rsb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	rsb_in_if.sink      in_ch,
	input  logic        s1_take,
	output logic        accept,
	output res_t        res_s1,
	output logic        valid_s1
);

	logic [31:0] cursor_q, cursor_d;
	logic [31:0] row_start_q, row_start_d;
	logic [15:0] rows_left_q, rows_left_d;
	logic [6:0]  run_left_q, run_left_d;
	logic        row_flag_q, row_flag_d;
	logic        active_q, active_d;
	logic [15:0] pitch_q;

	logic signed [16:0] tx;
	logic signed [16:0] ty;
	logic [31:0]        start_off;
	res_t               res;
	op_t                op;

	// The first stage takes a new item whenever it is empty or its current one moves on.
	assign in_ch.ready = !valid_s1 || s1_take;
	assign accept      = in_ch.valid && in_ch.ready;
	assign op          = op_t'(in_ch.operation);

	// Origin of a new sprite and its byte offset in the destination.
	assign tx = 17'(in_ch.coord_x) + 17'(in_ch.offset_x);
	assign ty = 17'(in_ch.coord_y) + 17'(in_ch.offset_y);
	assign start_off = ({16'd0, pitch_q} * {16'd0, ty[15:0]}) + {15'd0, tx[15:0], 1'b0};

	// Next-state and result decode for one item.
	always_comb begin
		cursor_d    = cursor_q;
		row_start_d = row_start_q;
		rows_left_d = rows_left_q;
		run_left_d  = run_left_q;
		row_flag_d  = row_flag_q;
		active_d    = active_q;
		res.we      = 1'b0;
		res.shadow  = 1'b0;
		res.woff    = cursor_q;
		res.done    = 1'b0;
		res.status  = ST_OK;
		case (op)
			OP_START: begin
				if (tx[16] || ty[16]) begin
					res.status = ST_REJECT;
					active_d   = 1'b0;
					run_left_d = '0;
				end else begin
					cursor_d    = start_off;
					row_start_d = start_off;
					rows_left_d = in_ch.height;
					run_left_d  = '0;
					row_flag_d  = ty[0];
					active_d    = 1'b1;
				end
				res.woff = cursor_d;
			end
			OP_BYTE: begin
				if (!active_q) begin
					res.status = ST_IDLE_BYTE;
				end else if (run_left_q != '0) begin
					// Literal pixel: depth test now, color lookup in the next stage.
					if (in_ch.src_byte == SHADOW_PIXEL) begin
						res.shadow = 1'b1;
						res.we     = in_ch.depth_at_cursor < in_ch.ref_depth;
					end else begin
						res.we = (in_ch.depth_at_cursor <= in_ch.ref_depth) ||
							(row_flag_q == cursor_q[1]);
					end
					cursor_d   = cursor_q + 32'd2;
					run_left_d = run_left_q - 7'd1;
				end else if (in_ch.src_byte == 8'd0) begin
					// Row end: step to the next row and flip the checkerboard phase.
					row_start_d = row_start_q + {16'd0, pitch_q};
					cursor_d    = row_start_d;
					row_flag_d  = !row_flag_q;
					rows_left_d = rows_left_q - 16'd1;
					if (rows_left_q == 16'd1) begin
						res.done = 1'b1;
						active_d = 1'b0;
					end
				end else if (in_ch.src_byte[7]) begin
					cursor_d = cursor_q + {24'd0, in_ch.src_byte[6:0], 1'b0};
				end else begin
					run_left_d = in_ch.src_byte[6:0];
				end
			end
			default: begin
			end
		endcase
		res.next_off = cursor_d;
	end

	// Sprite state, pitch register and the first pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			row_start_q <= '0;
			rows_left_q <= '0;
			run_left_q  <= '0;
			row_flag_q  <= 1'b0;
			active_q    <= 1'b0;
			pitch_q     <= PITCH_RESET;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				pitch_q <= cfg_wdata;
			end
			if (accept) begin
				cursor_q    <= cursor_d;
				row_start_q <= row_start_d;
				rows_left_q <= rows_left_d;
				run_left_q  <= run_left_d;
				row_flag_q  <= row_flag_d;
				active_q    <= active_d;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Payload of the first stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// A held stage keeps its result until the output stage takes it.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_take |=> valid_s1 && $stable(res_s1))
		else $error("first stage changed while held");

	// The last row end leaves the block idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.done |=> !active_q)
		else $error("block still active after sprite end");

	// Rejected or idle items never write a pixel.
	a_status_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (res_s1.status != ST_OK) |-> !res_s1.we)
		else $error("write enabled on a non-ok item");

endmodule

// File: rtl/rsb_out.sv
// Output stage: resolves the color from the table read data and holds the result.
// Depends on rsb_pkg and the result interface in rsb_ifs.sv.
module rsb_out
	import rsb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  res_t                  res_s1,
	input  logic [PIXEL_BITS-1:0] pal_rdata,
	input  logic [PIXEL_BITS-1:0] shade_rdata,
	output logic                  s1_take,
	rsb_out_if.source             out_ch
);

	logic                  valid_q;
	logic                  we_q;
	logic [31:0]           woff_q;
	logic [PIXEL_BITS-1:0] wval_q;
	logic [31:0]           next_q;
	logic                  done_q;
	logic [1:0]            status_q;
	logic [PIXEL_BITS-1:0] color;

	// The output register is free when empty or when its result is taken.
	assign s1_take = !valid_q || out_ch.ready;

	// Color from the table selected by the pixel kind; zero when not written.
	always_comb begin
		color = '0;
		if (res_s1.we) begin
			color = res_s1.shadow ? shade_rdata : pal_rdata;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s1_take) begin
			valid_q <= valid_s1;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (s1_take && valid_s1) begin
			we_q     <= res_s1.we;
			woff_q   <= res_s1.woff;
			wval_q   <= color;
			next_q   <= res_s1.next_off;
			done_q   <= res_s1.done;
			status_q <= res_s1.status;
		end
	end

	assign out_ch.valid        = valid_q;
	assign out_ch.write_enable = we_q;
	assign out_ch.write_offset = woff_q;
	assign out_ch.write_value  = wval_q;
	assign out_ch.next_offset  = next_q;
	assign out_ch.sprite_done  = done_q;
	assign out_ch.status       = status_q;

	// A written pixel always advances the cursor by one pixel.
	a_write_step: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && we_q |-> next_q == woff_q + 32'd2)
		else $error("cursor did not step after a pixel write");

endmodule

// File: rtl/rle_sprite_blit_zshadow_obscured_unit.sv
// Run-length sprite blitter with depth test, shadow shading and checkerboard see-through.
// Pipeline: the first stage and the palette and shade reads are loaded at the item transfer,
// then the output register when it is empty or its result is taken.
// Throughput: one item per cycle while the receiver takes results; a held output stalls the input.
// Reset clears the sprite state and sets the pitch to 1280; the palette and shade tables
// are not cleared and hold undefined data until loaded.
module rle_sprite_blit_zshadow_obscured_unit
	import rsb_pkg::*;
#(
	parameter int SHADE_ENTRIES = SHADE_ENTRIES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	rsb_in_if.sink      in_ch,
	rsb_out_if.source   out_ch
);

	// Shade table size must be a power of two, which the block does not check; the read index wraps by dropping high bits.
	localparam int SHADE_AW = $clog2(SHADE_ENTRIES);

	logic                  accept;
	logic                  s1_take;
	logic                  valid_s1;
	res_t                  res_s1;
	logic [PIXEL_BITS-1:0] pal_rdata;
	logic [PIXEL_BITS-1:0] shade_rdata;
	logic                  pal_we;
	logic                  shade_we;

	// Table loads; an index beyond the table is dropped.
	assign pal_we   = accept && (op_t'(in_ch.operation) == OP_LOAD_PAL) &&
		(in_ch.table_index[15:PAL_AW] == '0);
	assign shade_we = accept && (op_t'(in_ch.operation) == OP_LOAD_SHADE) &&
		({1'b0, in_ch.table_index} < 17'(SHADE_ENTRIES));

	rsb_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.s1_take  (s1_take),
		.accept   (accept),
		.res_s1   (res_s1),
		.valid_s1 (valid_s1)
	);

	rsb_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (pal_we),
		.waddr(in_ch.table_index[PAL_AW-1:0]),
		.wdata(in_ch.table_value),
		.re   (accept),
		.raddr(in_ch.src_byte),
		.rdata(pal_rdata)
	);

	rsb_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(SHADE_ENTRIES)
	) u_shade (
		.clk  (clk),
		.we   (shade_we),
		.waddr(in_ch.table_index[SHADE_AW-1:0]),
		.wdata(in_ch.table_value),
		.re   (accept),
		.raddr(in_ch.dest_pixel[SHADE_AW-1:0]),
		.rdata(shade_rdata)
	);

	rsb_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.res_s1     (res_s1),
		.pal_rdata  (pal_rdata),
		.shade_rdata(shade_rdata),
		.s1_take    (s1_take),
		.out_ch     (out_ch)
	);

endmodule

// File: tb/tb.sv
// Self-checking testbench for the run-length sprite blitter with depth test.
// Depends on rsb_pkg, the rsb_in_if/rsb_out_if interfaces and the top-level unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rsb_pkg::*;

	localparam int SHADE_N      = SHADE_ENTRIES_DEFAULT;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 240;

	// Receiver stall patterns.
	typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} rx_mode_t;

	// One item on the input channel.
	typedef struct {
		op_t                op;
		logic [7:0]         src_byte;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
		logic [15:0]        height;
		logic [15:0]        ref_depth;
		logic [15:0]        dest_pixel;
		logic [15:0]        depth_at_cursor;
		logic [15:0]        table_index;
		logic [15:0]        table_value;
	} blit_item_t;

	// One result on the output channel.
	typedef struct {
		logic        write_enable;
		logic [31:0] write_offset;
		logic [15:0] write_value;
		logic [31:0] next_offset;
		logic        sprite_done;
		status_t     status;
	} pixel_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	rsb_in_if  in_ch();
	rsb_out_if out_ch();

	rle_sprite_blit_zshadow_obscured_unit #(
		.SHADE_ENTRIES(SHADE_N)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// Expected pixel results, oldest first.
	pixel_result_t pixel_results_q[$];

	// Shadow copy of the blitter state.
	logic [15:0] pal_model [PALETTE_ENTRIES];
	bit          pal_loaded [PALETTE_ENTRIES];
	logic [15:0] shade_model [SHADE_N];
	bit          shade_loaded [SHADE_N];
	logic [7:0]  pal_list[$];
	logic [15:0] shade_list[$];
	logic [31:0] cur_off = '0;
	logic [31:0] row_off = '0;
	logic [15:0] rows_left = '0;
	logic [6:0]  run_left = '0;
	logic        row_flag = 1'b0;
	logic        sprite_active = 1'b0;
	logic [15:0] pitch = PITCH_RESET;

	int  mismatches = 0;
	int  items_sent = 0;
	int  burst_left = 0;
	int  gap_max = 0;
	int  cycle_count = 0;
	bit  hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Work out the result of one accepted item and advance the shadow state.
	function automatic pixel_result_t predict_blit(blit_item_t it);
		pixel_result_t r;
		int tx;
		int ty;
		logic [31:0] ux;
		logic [31:0] uy;
		r.write_enable = 1'b0;
		r.write_value  = '0;
		r.sprite_done  = 1'b0;
		r.status       = ST_OK;
		r.write_offset = cur_off;
		case (it.op)
			OP_START: begin
				tx = int'(it.coord_x) + int'(it.offset_x);
				ty = int'(it.coord_y) + int'(it.offset_y);
				if (tx < 0 || ty < 0) begin
					r.status = ST_REJECT;
					sprite_active = 1'b0;
					run_left = '0;
				end else begin
					ux = tx;
					uy = ty;
					cur_off = {16'd0, pitch} * uy + (ux << 1);
					row_off = cur_off;
					rows_left = it.height;
					run_left = '0;
					row_flag = uy[0];
					sprite_active = 1'b1;
				end
				r.write_offset = cur_off;
			end
			OP_BYTE: begin
				if (!sprite_active) begin
					r.status = ST_IDLE_BYTE;
				end else if (run_left != 0) begin
					// Literal pixel: shadow uses a strict test, others allow see-through.
					if (it.src_byte == SHADOW_PIXEL) begin
						if (it.depth_at_cursor < it.ref_depth) begin
							r.write_enable = 1'b1;
							r.write_value = shade_model[int'(it.dest_pixel) % SHADE_N];
						end
					end else if (it.depth_at_cursor <= it.ref_depth ||
							row_flag == cur_off[1]) begin
						r.write_enable = 1'b1;
						r.write_value = pal_model[it.src_byte];
					end
					cur_off = cur_off + 32'd2;
					run_left = run_left - 7'd1;
				end else if (it.src_byte == 8'h00) begin
					// Row end: step to the next row and flip the checkerboard phase.
					row_off = row_off + {16'd0, pitch};
					cur_off = row_off;
					row_flag = ~row_flag;
					if (rows_left == 16'd1) begin
						rows_left = '0;
						r.sprite_done = 1'b1;
						sprite_active = 1'b0;
					end else begin
						rows_left = rows_left - 16'd1;
					end
				end else if (it.src_byte[7]) begin
					cur_off = cur_off + {24'd0, it.src_byte[6:0], 1'b0};
				end else begin
					run_left = it.src_byte[6:0];
				end
			end
			OP_LOAD_PAL: begin
				if (it.table_index < PALETTE_ENTRIES) begin
					pal_model[it.table_index[PAL_AW-1:0]] = it.table_value;
					if (!pal_loaded[it.table_index[PAL_AW-1:0]]) begin
						pal_loaded[it.table_index[PAL_AW-1:0]] = 1'b1;
						pal_list.push_back(it.table_index[PAL_AW-1:0]);
					end
				end
			end
			default: begin
				if (it.table_index < SHADE_N) begin
					shade_model[it.table_index] = it.table_value;
					if (!shade_loaded[it.table_index]) begin
						shade_loaded[it.table_index] = 1'b1;
						shade_list.push_back(it.table_index);
					end
				end
			end
		endcase
		r.next_offset = cur_off;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
	endtask

	// Send one item: bursts of random length with random gaps, then wait for the transfer.
	task automatic send_item(blit_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				@(negedge clk);
				in_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_ch.operation       = it.op;
		in_ch.src_byte        = it.src_byte;
		in_ch.coord_x         = it.coord_x;
		in_ch.coord_y         = it.coord_y;
		in_ch.offset_x        = it.offset_x;
		in_ch.offset_y        = it.offset_y;
		in_ch.height          = it.height;
		in_ch.ref_depth       = it.ref_depth;
		in_ch.dest_pixel      = it.dest_pixel;
		in_ch.depth_at_cursor = it.depth_at_cursor;
		in_ch.table_index     = it.table_index;
		in_ch.table_value     = it.table_value;
		in_ch.valid           = 1'b1;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		pixel_results_q.push_back(predict_blit(it));
		items_sent++;
	endtask

	// Fields that the operation does not use carry random values.
	function automatic blit_item_t noise_fields(op_t op);
		blit_item_t it;
		it.op              = op;
		it.src_byte        = 8'($urandom);
		it.coord_x         = 16'($urandom);
		it.coord_y         = 16'($urandom);
		it.offset_x        = 16'($urandom);
		it.offset_y        = 16'($urandom);
		it.height          = 16'($urandom);
		it.ref_depth       = 16'($urandom);
		it.dest_pixel      = 16'($urandom);
		it.depth_at_cursor = 16'($urandom);
		it.table_index     = 16'($urandom);
		it.table_value     = 16'($urandom);
		return it;
	endfunction

	task automatic send_start(int cx, int cy, int ox, int oy, logic [15:0] h,
			logic [15:0] dref);
		blit_item_t it;
		it = noise_fields(OP_START);
		it.coord_x   = 16'(cx);
		it.coord_y   = 16'(cy);
		it.offset_x  = 16'(ox);
		it.offset_y  = 16'(oy);
		it.height    = h;
		it.ref_depth = dref;
		send_item(it);
	endtask

	task automatic send_byte(logic [7:0] b, logic [15:0] dref, logic [15:0] dpix,
			logic [15:0] dcur);
		blit_item_t it;
		it = noise_fields(OP_BYTE);
		it.src_byte        = b;
		it.ref_depth       = dref;
		it.dest_pixel      = dpix;
		it.depth_at_cursor = dcur;
		send_item(it);
	endtask

	task automatic send_load(op_t op, logic [15:0] idx, logic [15:0] val);
		blit_item_t it;
		it = noise_fields(op);
		it.table_index = idx;
		it.table_value = val;
		send_item(it);
	endtask

	task automatic send_random_load();
		if ($urandom_range(0, 1) == 0)
			send_load(OP_LOAD_PAL, ($urandom_range(0, 9) == 0) ? 16'($urandom) :
				16'($urandom_range(0, PALETTE_ENTRIES - 1)), 16'($urandom));
		else
			send_load(OP_LOAD_SHADE, 16'($urandom_range(0, SHADE_N - 1)), 16'($urandom));
	endtask

	// A literal pixel drawn only from loaded table entries, with depth mostly near the sprite's.
	task automatic send_pixel(logic [15:0] dref);
		logic [7:0]  px;
		logic [15:0] dpix;
		logic [15:0] dcur;
		if ($urandom_range(0, 4) == 0)
			px = SHADOW_PIXEL;
		else
			px = pal_list[$urandom_range(0, pal_list.size() - 1)];
		if (px == SHADOW_PIXEL)
			dpix = shade_list[$urandom_range(0, shade_list.size() - 1)];
		else
			dpix = 16'($urandom);
		case ($urandom_range(0, 3))
			0: dcur = dref - 16'd1;
			1: dcur = dref;
			2: dcur = dref + 16'd1;
			default: dcur = 16'($urandom);
		endcase
		send_byte(px, dref, dpix, dcur);
	endtask

	// One sprite: mostly well formed, sometimes cut short, sometimes a stray byte or a table load instead.
	task automatic random_sprite();
		int dice;
		int tx;
		int ty;
		int ox;
		int oy;
		int rows;
		int len;
		logic [15:0] h;
		logic [15:0] dref;
		dice = $urandom_range(0, 99);
		if (dice < 8) begin
			// Inside an open run a stray byte is a pixel, so it uses loaded entries only.
			if (sprite_active && run_left != '0)
				send_pixel(16'($urandom));
			else
				send_byte(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			return;
		end
		if (dice < 14) begin
			send_random_load();
			return;
		end
		dref = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
		case ($urandom_range(0, 99))
			0, 1:    h = 16'd0;
			2, 3, 4: h = 16'($urandom);
			default: h = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(4, 6)) :
				16'($urandom_range(1, 3));
		endcase
		if (dice < 22) begin
			// Full-range placement, often rejected.
			send_start($urandom, $urandom, $urandom, $urandom, h, dref);
		end else begin
			tx = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65534) : $urandom_range(0, 700);
			ty = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65534) : $urandom_range(0, 500);
			ox = (tx > 32767) ? tx - 32767 : int'($urandom_range(0, 4000)) - 2000;
			oy = (ty > 32767) ? ty - 32767 : int'($urandom_range(0, 4000)) - 2000;
			send_start(tx - ox, ty - oy, ox, oy, h, dref);
		end
		rows = (h == 16'd0 || h > 16'd6) ? $urandom_range(1, 2) : int'(h);
		for (int row = 0; row < rows; row++) begin
			repeat ($urandom_range(0, 3)) begin
				if ($urandom_range(0, 9) < 4) begin
					send_byte({1'b1, 7'($urandom)}, dref, 16'($urandom), 16'($urandom));
				end else begin
					len = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 127) :
						$urandom_range(1, 4);
					send_byte(8'(len), dref, 16'($urandom), 16'($urandom));
					repeat (len) begin
						if ($urandom_range(0, 15) == 0)
							send_random_load();
						send_pixel(dref);
					end
				end
			end
			if ($urandom_range(0, 49) == 0)
				return;
			send_byte(8'h00, dref, 16'($urandom), 16'($urandom));
		end
	endtask

	// Stop offering items and wait until every expected result has come.
	task automatic wait_all_results();
		@(negedge clk);
		in_ch.valid = 1'b0;
		burst_left = 0;
		while (pixel_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_pitch(logic [15:0] value);
		wait_all_results();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		pitch = value;
	endtask

	// Stream bytes while idle, then table loads including ignored indexes.
	task automatic test_idle_and_tables();
		send_byte(8'h00, 16'd0, 16'd0, 16'd0);
		send_byte(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_load(OP_LOAD_PAL, 16'd0, 16'h0000);
		send_load(OP_LOAD_PAL, 16'd1, 16'hFFFF);
		send_load(OP_LOAD_PAL, 16'h007F, 16'h5A5A);
		send_load(OP_LOAD_PAL, 16'h00FF, 16'hA5A5);
		send_load(OP_LOAD_PAL, 16'h0100, 16'h1234);
		send_load(OP_LOAD_PAL, 16'hFFFF, 16'h4321);
		send_load(OP_LOAD_SHADE, 16'h0000, 16'h0F0F);
		send_load(OP_LOAD_SHADE, 16'hFFFF, 16'hF0F0);
	endtask

	// A two-row sprite that covers skips, runs, shadow, depth ties and see-through.
	task automatic test_directed_sprite();
		send_start(5, 0, -2, 1, 16'd2, 16'd100);
		send_byte(8'h83, 16'd100, 16'd0, 16'd0);
		send_byte(8'h80, 16'd100, 16'd0, 16'd0);
		send_byte(8'h05, 16'd100, 16'd0, 16'd0);
		send_byte(8'h01, 16'd100, 16'd7, 16'd100);
		send_byte(SHADOW_PIXEL, 16'd100, 16'hFFFF, 16'd99);
		send_byte(SHADOW_PIXEL, 16'd100, 16'h0000, 16'd100);
		send_byte(8'h7F, 16'd100, 16'd3, 16'd200);
		send_byte(8'hFF, 16'd100, 16'd3, 16'hFFFF);
		send_byte(8'h00, 16'd100, 16'd0, 16'd0);
		send_byte(8'hFF, 16'd100, 16'd0, 16'd0);
		send_byte(8'h01, 16'd100, 16'd0, 16'd0);
		send_byte(8'h00, 16'd100, 16'd0, 16'd0);
		send_byte(8'h00, 16'd100, 16'd0, 16'd0);
	endtask

	// Negative origins, the largest origin with zero height, and a start while active.
	task automatic test_origin_cases();
		send_start(-32768, 0, 0, 0, 16'd1, 16'd0);
		send_start(32767, 32767, 32767, 32767, 16'd0, 16'hFFFF);
		send_byte(8'h81, 16'd0, 16'd0, 16'd0);
		send_start(0, -1, 0, 0, 16'd1, 16'd0);
		send_byte(8'h00, 16'd0, 16'd0, 16'd0);
		send_start(0, 32767, 0, -32768, 16'd1, 16'd0);
	endtask

	// The receiver holds off while the sender keeps offering items, then everything drains.
	task automatic test_backpressure();
		int saved_gap;
		int target;
		saved_gap = gap_max;
		gap_max = 0;
		hold_req = 1'b1;
		target = items_sent + 60;
		while (items_sent < target) random_sprite();
		wait_all_results();
		gap_max = saved_gap;
	endtask

	// Random sprite streams under several pitch settings and idling levels.
	task automatic test_random_blits();
		logic [15:0] pitches [5];
		int target;
		pitches = '{16'd0, 16'hFFFF, 16'($urandom), 16'd2, PITCH_RESET};
		for (int p = 0; p < 5; p++) begin
			write_pitch(pitches[p]);
			gap_max = (p == 1) ? 0 : 3 + 4 * p;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) random_sprite();
		end
	endtask

	// Receiver: its own stall pattern, plus one long hold-off on request.
	initial begin : drive_ready
		rx_mode_t mode;
		int mode_left;
		int hold_left;
		int period;
		mode = RX_ALWAYS;
		mode_left = 0;
		hold_left = 0;
		period = 4;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready = 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_ch.ready = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
					period = $urandom_range(2, 7);
				end
				mode_left--;
				case (mode)
					RX_ALWAYS:   out_ch.ready = 1'b1;
					RX_MOSTLY:   out_ch.ready = ($urandom_range(0, 9) < 7);
					RX_PERIODIC: out_ch.ready = ((mode_left % period) != 0);
					default:     out_ch.ready = ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	// Compare each transferred result with the oldest expectation.
	always @(posedge clk) begin : check_results
		pixel_result_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pixel_results_q.size() == 0) begin
				report_mismatch("unexpected result", out_ch.write_offset, '0);
			end else begin
				want = pixel_results_q.pop_front();
				if (out_ch.write_enable !== want.write_enable)
					report_mismatch("write_enable", 32'(out_ch.write_enable),
						32'(want.write_enable));
				if (out_ch.write_offset !== want.write_offset)
					report_mismatch("write_offset", out_ch.write_offset, want.write_offset);
				if (out_ch.write_value !== want.write_value)
					report_mismatch("write_value", 32'(out_ch.write_value),
						32'(want.write_value));
				if (out_ch.next_offset !== want.next_offset)
					report_mismatch("next_offset", out_ch.next_offset, want.next_offset);
				if (out_ch.sprite_done !== want.sprite_done)
					report_mismatch("sprite_done", 32'(out_ch.sprite_done),
						32'(want.sprite_done));
				if (out_ch.status !== want.status)
					report_mismatch("status", 32'(out_ch.status), 32'(want.status));
			end
		end
	end

	// Watchdog on the total run length.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// Reset once, run the tests in turn, then report.
	initial begin : run_tests
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		in_ch.valid           = 1'b0;
		in_ch.operation       = '0;
		in_ch.src_byte        = '0;
		in_ch.coord_x         = '0;
		in_ch.coord_y         = '0;
		in_ch.offset_x        = '0;
		in_ch.offset_y        = '0;
		in_ch.height          = '0;
		in_ch.ref_depth       = '0;
		in_ch.dest_pixel      = '0;
		in_ch.depth_at_cursor = '0;
		in_ch.table_index     = '0;
		in_ch.table_value     = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		gap_max = 3;
		test_idle_and_tables();
		test_directed_sprite();
		test_origin_cases();
		test_backpressure();
		test_random_blits();
		wait_all_results();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
